// ===== hdl/brb_pkg.sv =====
// Shared declarations for the byte ring buffer: command and status codes,
// field widths, default depth and the controller-to-datapath command bundle.
// No dependencies.
package brb_pkg;

  localparam int unsigned DEPTH_DEF = 1024;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned IN_TW   = 32;
  localparam int unsigned OUT_TW  = 56;

  localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DRAIN     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UPDATE    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic load;    // capture the input transfer
    logic exec;    // apply the command to indices and store
    logic finish;  // load the result register
  } brb_ctl_t;

endpackage

// ===== hdl/brb_ctrl.sv =====
// Sequencing state machine for the byte ring buffer.
// Depends on brb_pkg; drives the datapath through brb_ctl_t.
module brb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic            out_busy,
  output brb_pkg::brb_ctl_t ctl
);
  import brb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_busy) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/brb_dp.sv =====
// Datapath of the byte ring buffer: item register, head/tail indices,
// single-port byte store and result register. Depends on brb_pkg.
module brb_dp #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  brb_pkg::brb_ctl_t           ctl,
  input  logic [brb_pkg::IN_TW-1:0]   in_tdata,
  output logic                        out_busy,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [brb_pkg::OUT_TW-1:0]  out_tdata
);
  import brb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [7:0] mem [DEPTH];

  logic [CMD_W-1:0]  cmd_r;
  logic [BYTE_W-1:0] din_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  off_r;

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] used_c, contig_c, free_c;
  logic [CW-1:0] cnt_w, off_w, front_sum, upd_sum, tail_back;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [BYTE_W-1:0] rd_data_r;

  logic [CNT_W-1:0] done_r, done_nxt;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic             drain_ok_r, drain_ok_nxt;

  logic              out_valid_r;
  logic [OUT_TW-1:0] out_data_r;

  assign cnt_w = CW'(cnt_r);
  assign off_w = CW'(off_r);

  assign used_c = (tail_r >= head_r) ? (CW'(tail_r) - CW'(head_r))
                                     : (CW'(tail_r) + DEPTH_W - CW'(head_r));
  assign free_c = DEPTH_W - CW'(1) - used_c;

  always_comb begin
    if (head_r > tail_r)       contig_c = CW'(head_r) - CW'(tail_r) - CW'(1);
    else if (head_r == '0)     contig_c = DEPTH_W - CW'(tail_r) - CW'(1);
    else                       contig_c = DEPTH_W - CW'(tail_r);
  end

  assign front_sum = CW'(head_r) + cnt_w;
  assign upd_sum   = CW'(head_r) + off_w;
  assign tail_back = (CW'(tail_r) >= cnt_w) ? (CW'(tail_r) - cnt_w)
                                            : (CW'(tail_r) + DEPTH_W - cnt_w);

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    done_nxt     = '0;
    status_nxt   = ST_OK;
    drain_ok_nxt = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = head_r;
    case (cmd_r)
      CMD_PUSH: begin
        mem_addr = tail_r;
        if (used_c >= DEPTH_W - CW'(1)) begin
          status_nxt = ST_FULL;
        end else begin
          mem_we   = 1'b1;
          tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + AW'(1);
          done_nxt = CNT_W'(1);
        end
      end
      CMD_DRAIN: begin
        if (used_c == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          drain_ok_nxt = 1'b1;
          done_nxt     = CNT_W'(1);
          if (used_c == CW'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            head_nxt = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (cnt_r != '0) begin
          if (cnt_w >= used_c) begin
            done_nxt = CNT_W'(used_c);
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            done_nxt = cnt_r;
            if (cmd_r == CMD_POP_FRONT)
              head_nxt = (front_sum >= DEPTH_W) ? AW'(front_sum - DEPTH_W) : AW'(front_sum);
            else
              tail_nxt = AW'(tail_back);
          end
        end
      end
      CMD_UPDATE: begin
        mem_addr = (upd_sum >= DEPTH_W) ? AW'(upd_sum - DEPTH_W) : AW'(upd_sum);
        if (off_w >= used_c) status_nxt = ST_RANGE;
        else                 mem_we     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if (mem_we) mem[mem_addr] <= din_r;
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_tdata[2:0];
      din_r <= in_tdata[10:3];
      cnt_r <= in_tdata[20:11];
      off_r <= in_tdata[30:21];
    end
    if (ctl.exec) begin
      done_r     <= done_nxt;
      status_r   <= status_nxt;
      drain_ok_r <= drain_ok_nxt;
    end
    if (ctl.finish) begin
      out_data_r <= {6'd0, status_r, CNT_W'(contig_c), CNT_W'(free_c), CNT_W'(used_c),
                     done_r, (drain_ok_r ? rd_data_r : 8'd0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.exec) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
      if (ctl.finish)     out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_busy   = out_valid_r && !out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/byte_ring_buffer.sv =====
// Byte ring buffer, top level: controller plus datapath. Depends on brb_pkg,
// brb_ctrl and brb_dp. A command goes through capture, store access and result
// load in order, the result load waiting while out_tready low holds the result
// register; no new command is taken before the result load of the last one.
// Reset (rst_n low, synchronous) empties the buffer; store contents are kept.
module byte_ring_buffer #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // cmd[2:0], data_in[10:3], count[20:11], offset[30:21], zero pad
  input  logic [brb_pkg::IN_TW-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // data_out[7:0], done_count[17:8], used_count[27:18], free_count[37:28],
  // contiguous_count[47:38], status[49:48], zero pad
  output logic [brb_pkg::OUT_TW-1:0]  out_tdata
);
  import brb_pkg::*;

  brb_ctl_t ctl;
  logic     out_busy;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_busy  (out_busy),
    .ctl       (ctl)
  );

  brb_dp #(.DEPTH(DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_tdata   (in_tdata),
    .out_busy   (out_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/brb_checker.sv =====
// Port-level checks for byte_ring_buffer, attached by bind.
// Depends on brb_pkg and the byte_ring_buffer port list.
module brb_port_checks #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [brb_pkg::IN_TW-1:0]   in_tdata,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [brb_pkg::OUT_TW-1:0]  out_tdata
);
  import brb_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(DEPTH - 1);

  logic [CNT_W-1:0] cnt_sum;
  assign cnt_sum = out_tdata[27:18] + out_tdata[37:28];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while busy");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_sum == CAP)
    else $error("used plus free does not match depth");

  a_full_nothing_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[49:48] == ST_FULL |-> out_tdata[17:8] == '0)
    else $error("rejected push reports a transfer");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind byte_ring_buffer brb_port_checks #(.DEPTH(DEPTH)) u_brb_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
